// File: sv/vector4_normalize_macros.svh
// Assertion macros for the vector normalization block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef VECTOR4_NORMALIZE_MACROS_SVH
`define VECTOR4_NORMALIZE_MACROS_SVH

// Implication checked in the same cycle, quiet during reset.
`define VN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle, quiet during reset.
`define VN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/vn_pkg.sv
// Package for the vector normalization block: payload structs, widths, depths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
	localparam int COMP_W  = 32;
	localparam int SUM_W   = 65;
	localparam int ROOT_W  = 33;
	localparam int QUO_W   = 31;
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = 32;
	localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(1) << 30;

	typedef struct packed {
		logic signed [COMP_W-1:0] comp_x;
		logic signed [COMP_W-1:0] comp_y;
		logic signed [COMP_W-1:0] comp_z;
		logic signed [COMP_W-1:0] comp_w;
	} vn_in_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] unit_x;
		logic signed [COMP_W-1:0] unit_y;
		logic signed [COMP_W-1:0] unit_z;
		logic signed [COMP_W-1:0] unit_w;
		logic        [COMP_W-1:0] length;
		logic                     zero_length;
		logic                     not_vector;
	} vn_out_t;

	// Data that rides beside the root pipeline
	typedef struct packed {
		logic [3:0][COMP_W-1:0] mag;
		logic [3:0]             neg;
		logic                   wnz;
	} vn_side_t;

	// Data that rides beside the divider lanes
	typedef struct packed {
		logic [3:0]        neg;
		logic              wnz;
		logic [ROOT_W-1:0] root;
	} vn_tail_t;
endpackage
`default_nettype wire

// File: sv/vector4_normalize.sv
// Pipeline: square, sum, 32 root stages, 32 divider stages, output register.
// Throughput: one tuple per cycle while the output is not stalled.
// The root resolves one bit per stage; each divider lane loads, then resolves one bit per step.
// A stalled output freezes the whole pipeline. Reset (arst_n, asynchronous)
// clears all valid bits; no clearing pass.
// Top level of the vector normalization block; depends on vn_pkg, the lanes, vn_sqrt and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "vector4_normalize_macros.svh"
module vector4_normalize (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire vn_pkg::vn_in_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output vn_pkg::vn_out_t     out_data
);
	import vn_pkg::*;

	localparam int LAT = 2 + SQRT_STAGES + DIV_STAGES + 1;

	logic                         en;
	logic [LAT-1:0]               vld_q;
	logic [3:0][COMP_W-1:0]       comps;
	logic [3:0][COMP_W-1:0]       mag_s1;
	logic [3:0][2*COMP_W-1:0]     sq_s1;
	logic [3:0]                   neg_s1;
	logic                         wnz_s1;
	logic [SUM_W-1:0]             sum_s2;
	vn_side_t                     side_s2;
	vn_side_t                     side_q [0:SQRT_STAGES-1];
	logic [ROOT_W-1:0]            root;
	vn_tail_t                     tail_q [0:DIV_STAGES-1];
	logic [3:0][QUO_W-1:0]        quo;
	logic [3:0][COMP_W-1:0]       unit;
	vn_out_t                      out_q;

	// Advance everything unless a finished result is held
	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];
	assign out_data  = out_q;

	// Shift the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Square lanes
	assign comps = {in_data.comp_w, in_data.comp_z, in_data.comp_y, in_data.comp_x};
	for (genvar i = 0; i < 4; i++) begin : g_sq
		vn_sq_lane u_sq (
			.clk    (clk),
			.en     (en),
			.comp   (comps[i]),
			.mag_s1 (mag_s1[i]),
			.sq_s1  (sq_s1[i]),
			.neg_s1 (neg_s1[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wnz_s1 <= in_data.comp_w != '0;
		end
	end

	// Merge the squares into one sum
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2])
				+ SUM_W'(sq_s1[3]);
			side_s2 <= '{mag: mag_s1, neg: neg_s1, wnz: wnz_s1};
		end
	end

	vn_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.sum  (sum_s2),
		.root (root)
	);

	// Hold the side data beside the root stages
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s2;
			for (int k = 1; k < SQRT_STAGES; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// Divider lanes
	for (genvar i = 0; i < 4; i++) begin : g_div
		vn_div_lane u_div (
			.clk  (clk),
			.en   (en),
			.mag  (side_q[SQRT_STAGES-1].mag[i]),
			.root (root),
			.quo  (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_q[0] <= '{neg: side_q[SQRT_STAGES-1].neg,
				wnz: side_q[SQRT_STAGES-1].wnz, root: root};
			for (int k = 1; k < DIV_STAGES; k++) begin
				tail_q[k] <= tail_q[k-1];
			end
		end
	end

	// Apply signs, force zero for a zero length
	for (genvar i = 0; i < 4; i++) begin : g_sign
		always_comb begin
			if (tail_q[DIV_STAGES-1].root == '0) begin
				unit[i] = '0;
			end else if (tail_q[DIV_STAGES-1].neg[i]) begin
				unit[i] = -COMP_W'(quo[i]);
			end else begin
				unit[i] = COMP_W'(quo[i]);
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.unit_x      <= unit[0];
			out_q.unit_y      <= unit[1];
			out_q.unit_z      <= unit[2];
			out_q.unit_w      <= unit[3];
			out_q.length      <= tail_q[DIV_STAGES-1].root[32] ? '1
				: tail_q[DIV_STAGES-1].root[31:0];
			out_q.zero_length <= tail_q[DIV_STAGES-1].root == '0;
			out_q.not_vector  <= tail_q[DIV_STAGES-1].wnz;
		end
	end

	`VN_ASSERT_IMP(a_stall_blocks, out_valid && !out_ready, !in_ready,
		"input taken while output stalled")
	`VN_ASSERT_IMP(a_zero_units, out_valid && out_data.zero_length,
		out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0
		&& out_data.unit_w == '0,
		"zero length with nonzero units")
	`VN_ASSERT_IMP(a_zero_len, out_valid, out_data.zero_length == (out_data.length == '0),
		"zero flag disagrees with length")
	`VN_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid,
		"result dropped while stalled")
endmodule
`default_nettype wire

// File: sv/vn_sq_lane.sv
// One squaring lane: magnitude of a signed component and its square.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vn_sq_lane (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic signed [vn_pkg::COMP_W-1:0] comp,
	output logic        [vn_pkg::COMP_W-1:0]     mag_s1,
	output logic        [2*vn_pkg::COMP_W-1:0]   sq_s1,
	output logic                                 neg_s1
);
	import vn_pkg::*;

	logic [COMP_W-1:0] mag;

	// Take the magnitude; the most negative value maps to 2^31
	assign mag = comp[COMP_W-1] ? COMP_W'(-comp) : COMP_W'(comp);

	// Register the square
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag;
			sq_s1  <= (2*COMP_W)'(mag) * (2*COMP_W)'(mag);
			neg_s1 <= comp[COMP_W-1];
		end
	end
endmodule
`default_nettype wire

// File: sv/vn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vn_sqrt (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [vn_pkg::SUM_W-1:0]   sum,
	output logic      [vn_pkg::ROOT_W-1:0]  root
);
	import vn_pkg::*;

	localparam int REM_W = 34;

	logic [REM_W-1:0]   rem_s  [0:SQRT_STAGES];
	logic [31:0]        res_s  [0:SQRT_STAGES];
	logic [63:0]        val_s  [0:SQRT_STAGES];
	logic               ovf_s  [0:SQRT_STAGES];

	assign rem_s[0] = '0;
	assign res_s[0] = '0;
	assign val_s[0] = sum[63:0];
	assign ovf_s[0] = sum[64];

	// One restoring step per stage: bring down two bits, try the next root bit
	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
		logic [REM_W+1:0] rem_n;
		logic [REM_W+1:0] trial;
		logic             take;
		assign rem_n = {rem_s[k], val_s[k][63:62]};
		assign trial = {2'b00, res_s[k], 2'b01};
		assign take  = rem_n >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? REM_W'(rem_n - trial) : REM_W'(rem_n);
				res_s[k+1] <= {res_s[k][30:0], take};
				val_s[k+1] <= {val_s[k][61:0], 2'b00};
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// A sum of 2^64 has the root 2^32
	assign root = ovf_s[SQRT_STAGES] ? (ROOT_W'(1) << 32)
		: {1'b0, res_s[SQRT_STAGES]};
endmodule
`default_nettype wire

// File: sv/vn_div_lane.sv
// One divider lane: rounded magnitude/root as Q1.30, one quotient bit per restoring step.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vn_div_lane (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [vn_pkg::COMP_W-1:0]  mag,
	input  wire logic [vn_pkg::ROOT_W-1:0]  root,
	output logic      [vn_pkg::QUO_W-1:0]   quo
);
	import vn_pkg::*;

	localparam int REM_W = ROOT_W;
	localparam int NUM_W = 63;

	logic [REM_W-1:0]  rem_s [0:DIV_STAGES-1];
	logic [QUO_W-1:0]  num_s [0:DIV_STAGES-1];
	logic [QUO_W-1:0]  q_s   [0:DIV_STAGES-1];
	logic [ROOT_W-1:0] den_s [0:DIV_STAGES-1];
	logic [NUM_W-1:0]  num;

	// Form the rounded dividend: mag * 2^30 + root / 2
	assign num = (NUM_W'(mag) << 30) + NUM_W'(root >> 1);

	// Load the upper dividend bits as the starting remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= REM_W'(num[NUM_W-1:QUO_W]);
			num_s[0] <= num[QUO_W-1:0];
			q_s[0]   <= '0;
			den_s[0] <= root;
		end
	end

	// Restoring steps, most significant quotient bit first
	for (genvar k = 0; k < DIV_STAGES-1; k++) begin : g_step
		logic [REM_W:0] rem_n;
		logic           take;
		assign rem_n = {rem_s[k], num_s[k][QUO_W-1]};
		assign take  = rem_n >= {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? REM_W'(rem_n - {1'b0, den_s[k]}) : REM_W'(rem_n);
				num_s[k+1] <= {num_s[k][QUO_W-2:0], 1'b0};
				q_s[k+1]   <= {q_s[k][QUO_W-2:0], take};
				den_s[k+1] <= den_s[k];
			end
		end
	end

	// Clamp to one
	assign quo = (q_s[DIV_STAGES-1] > UNIT_ONE) ? UNIT_ONE : q_s[DIV_STAGES-1];
endmodule
`default_nettype wire
